// ===== rtl/lfd_pkg.sv =====
// types and constants shared by the link frame delimiter modules
package lfd_pkg;

  // header bytes and frame length rules
  localparam logic [7:0] START_ONE   = 8'h05;
  localparam logic [7:0] START_TWO   = 8'h64;
  localparam logic [7:0] MIN_LENGTH  = 8'd5;
  localparam int         BLOCK_SHIFT = 4;   // 16-byte check blocks
  localparam logic [8:0] HDR_BYTES   = 9'd3;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic {
    CMD_BODY   = 1'b0,
    CMD_HEADER = 1'b1
  } lfd_kind_t;

  // header expansion steps in the back part
  typedef enum logic [1:0] {
    STEP_SYNC1  = 2'd0,
    STEP_SYNC2  = 2'd1,
    STEP_LENGTH = 2'd2
  } lfd_step_t;

  typedef struct packed {
    lfd_kind_t  kind;
    logic [7:0] data;   // body byte, or length byte for a header
    logic [8:0] pos;
    logic [8:0] total;
    logic       last;
  } lfd_cmd_t;

endpackage

// ===== rtl/link_frame_delimiter.sv =====
// top level of the link frame delimiter
// Finds link frames in a received byte stream: bytes are grouped in threes
// while hunting, and a group reading 0x05, 0x64 and a length of at least 5
// opens a frame whose total (header, data and two check bytes per started
// 16-byte block) must not exceed MAX_FRAME_BYTES. Every byte of an accepted
// frame comes out with its offset, the frame total and first/last marks;
// check bytes are passed through unchecked. One byte is taken per cycle
// while the four-entry command queue has room; a header emits three output
// transfers from one queue entry, and the output side drains one transfer
// per cycle while out_ready is high, so the queue absorbs the header burst.
// An input transfer is written into a queue entry and then loaded into the
// output register before it appears at the output.
module link_frame_delimiter #(
  parameter int MAX_FRAME_BYTES = 292
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic [8:0] out_byte_position,
  output logic [8:0] out_frame_total,
  output logic       out_first_of_frame,
  output logic       out_last_of_frame
);
  import lfd_pkg::*;

  lfd_cmd_t q_wr_data, q_rd_data;
  logic     q_wr, q_rd, q_full, q_empty;

  // classification front end
  lfd_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  // decoupling queue
  lfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd     (q_rd),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  // output back end
  lfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rd_data         (q_rd_data),
    .q_empty           (q_empty),
    .q_rd              (q_rd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_frame_total   (out_frame_total),
    .out_first_of_frame(out_first_of_frame),
    .out_last_of_frame (out_last_of_frame)
  );

  // first byte of a frame sits at offset zero and carries a legal total
  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_of_frame |->
      out_byte_position == 9'd0 && out_frame_total >= 9'd10)
    else $error("first byte not at offset zero");

  // last byte of a frame sits at total minus one
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_frame |->
      out_byte_position == out_frame_total - 9'd1)
    else $error("last byte offset mismatch");

  // offset zero is always marked first
  a_zero_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_position == 9'd0 |-> out_first_of_frame)
    else $error("offset zero not marked first");

  // a completed non-last transfer is followed by the next offset of the same frame
  a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_frame ##1 out_valid |->
      out_byte_position == $past(out_byte_position) + 9'd1 &&
      out_frame_total == $past(out_frame_total))
    else $error("frame offsets not consecutive");

endmodule

// ===== rtl/lfd_front.sv =====
// front part: hunts for headers, sizes frames and queues byte commands
module lfd_front #(
  parameter int MAX_FRAME_BYTES = 292
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             q_full,
  output logic             q_wr,
  output lfd_pkg::lfd_cmd_t q_wr_data
);
  import lfd_pkg::*;

  logic       collecting_r, collecting_nxt;
  logic [1:0] held_count_r, held_count_nxt;
  logic [7:0] held0_r, held1_r;
  logic [8:0] remaining_r, remaining_nxt;
  logic [8:0] position_r, position_nxt;
  logic [8:0] total_r, total_nxt;

  logic       accept;
  logic [7:0] len_excess;
  logic [8:0] round_up;
  logic [4:0] blocks;
  logic [8:0] hdr_total;
  logic       hdr_ok;
  logic       last_byte;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // frame size from the length byte
  assign len_excess = in_rx_byte - MIN_LENGTH;
  assign round_up   = {1'b0, len_excess} + 9'd15;
  assign blocks     = round_up[8:BLOCK_SHIFT];
  assign hdr_total  = 9'd5 + {1'b0, in_rx_byte} + {3'b000, blocks, 1'b0};
  assign hdr_ok     = (held0_r == START_ONE) && (held1_r == START_TWO) &&
                      (in_rx_byte >= MIN_LENGTH) &&
                      (hdr_total <= 9'(MAX_FRAME_BYTES));
  assign last_byte  = (remaining_r <= 9'd1);

  // classification and command generation
  always_comb begin
    collecting_nxt = collecting_r;
    held_count_nxt = held_count_r;
    remaining_nxt  = remaining_r;
    position_nxt   = position_r;
    total_nxt      = total_r;
    q_wr           = 1'b0;
    q_wr_data      = '{kind: CMD_BODY, data: in_rx_byte, pos: position_r,
                       total: total_r, last: last_byte};
    if (accept) begin
      if (collecting_r) begin
        q_wr = 1'b1;
        if (last_byte) begin
          collecting_nxt = 1'b0;
          held_count_nxt = 2'd0;
          remaining_nxt  = 9'd0;
          position_nxt   = 9'd0;
        end else begin
          remaining_nxt = remaining_r - 9'd1;
          position_nxt  = position_r + 9'd1;
        end
      end else if (held_count_r < 2'd2) begin
        held_count_nxt = held_count_r + 2'd1;
      end else begin
        held_count_nxt = 2'd0;
        if (hdr_ok) begin
          q_wr           = 1'b1;
          q_wr_data      = '{kind: CMD_HEADER, data: in_rx_byte, pos: 9'd0,
                             total: hdr_total, last: 1'b0};
          collecting_nxt = 1'b1;
          total_nxt      = hdr_total;
          position_nxt   = HDR_BYTES;
          remaining_nxt  = hdr_total - HDR_BYTES;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      held_count_r <= 2'd0;
      remaining_r  <= 9'd0;
      position_r   <= 9'd0;
      total_r      <= 9'd0;
    end else begin
      collecting_r <= collecting_nxt;
      held_count_r <= held_count_nxt;
      remaining_r  <= remaining_nxt;
      position_r   <= position_nxt;
      total_r      <= total_nxt;
    end
  end

  // held header bytes
  always_ff @(posedge clk) begin
    if (accept && !collecting_r && held_count_r == 2'd0) held0_r <= in_rx_byte;
    if (accept && !collecting_r && held_count_r == 2'd1) held1_r <= in_rx_byte;
  end

endmodule

// ===== rtl/lfd_queue.sv =====
// short command queue between front and back
module lfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  lfd_pkg::lfd_cmd_t wr_data,
  output logic              full,
  input  logic              rd,
  output lfd_pkg::lfd_cmd_t rd_data,
  output logic              empty
);
  import lfd_pkg::*;

  lfd_cmd_t       slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt  = wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (wr && !rd) count_nxt = count_r + 1'b1;
    else if (rd && !wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) slot_r[wptr_r] <= wr_data;
  end

endmodule

// ===== rtl/lfd_back.sv =====
// back part: expands queued commands into output byte transfers
module lfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lfd_pkg::lfd_cmd_t q_rd_data,
  input  logic              q_empty,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_frame_byte,
  output logic [8:0]        out_byte_position,
  output logic [8:0]        out_frame_total,
  output logic              out_first_of_frame,
  output logic              out_last_of_frame
);
  import lfd_pkg::*;

  logic      valid_r, valid_nxt;
  lfd_step_t step_r, step_nxt;
  logic      load;
  logic [7:0] byte_nxt;
  logic [8:0] pos_nxt;
  logic       first_nxt;
  logic [7:0] byte_r;
  logic [8:0] pos_r, total_r;
  logic       first_r, last_r;

  assign load = !q_empty && (!valid_r || out_ready);

  // header step sequencing and queue pop
  always_comb begin
    step_nxt = step_r;
    q_rd     = 1'b0;
    if (load) begin
      if (q_rd_data.kind == CMD_BODY) begin
        q_rd = 1'b1;
      end else begin
        case (step_r)
          STEP_SYNC1: step_nxt = STEP_SYNC2;
          STEP_SYNC2: step_nxt = STEP_LENGTH;
          default: begin
            step_nxt = STEP_SYNC1;
            q_rd     = 1'b1;
          end
        endcase
      end
    end
    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  // output item selection
  always_comb begin
    byte_nxt  = q_rd_data.data;
    pos_nxt   = q_rd_data.pos;
    first_nxt = 1'b0;
    if (q_rd_data.kind == CMD_HEADER) begin
      case (step_r)
        STEP_SYNC1: begin
          byte_nxt  = START_ONE;
          pos_nxt   = 9'd0;
          first_nxt = 1'b1;
        end
        STEP_SYNC2: begin
          byte_nxt = START_TWO;
          pos_nxt  = 9'd1;
        end
        default: begin
          byte_nxt = q_rd_data.data;
          pos_nxt  = 9'd2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= STEP_SYNC1;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      pos_r   <= pos_nxt;
      total_r <= q_rd_data.total;
      first_r <= first_nxt;
      last_r  <= q_rd_data.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_frame_byte     = byte_r;
  assign out_byte_position  = pos_r;
  assign out_frame_total    = total_r;
  assign out_first_of_frame = first_r;
  assign out_last_of_frame  = last_r;

endmodule

// ===== tb/link_frame_delimiter_tb.sv =====
// self-checking testbench for the link frame delimiter
`timescale 1ns / 1ps

module link_frame_delimiter_tb;
  import lfd_pkg::*;

  localparam int MAX_FRAME_BYTES = 292;
  localparam int IDLE_LIMIT      = 5000;
  localparam int RANDOM_ITEMS    = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;

  // one output transfer of a delimited frame
  typedef struct packed {
    logic [7:0] data;
    logic [8:0] pos;
    logic [8:0] total;
    logic       first;
    logic       last;
  } frame_beat_t;

  // kinds of stimulus units in the random part
  typedef enum logic [2:0] {
    UNIT_FRAME,
    UNIT_NOISE,
    UNIT_SHORT_LEN,
    UNIT_BAD_SYNC,
    UNIT_SKEWED
  } unit_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_frame_byte;
  logic [8:0] out_byte_position;
  logic [8:0] out_frame_total;
  logic       out_first_of_frame;
  logic       out_last_of_frame;

  // frame size: header, data and two check bytes per started 16-byte block
  function automatic int frame_size(input logic [7:0] len);
    int d;
    d = int'(len) - int'(MIN_LENGTH);
    return int'(HDR_BYTES) + int'(len) + 2 + 2 * (d >> BLOCK_SHIFT)
           + (((d % (1 << BLOCK_SHIFT)) != 0) ? 2 : 0);
  endfunction

  class frame_scoreboard;
    frame_beat_t beats_due[$];
    int          errors;
    int          bytes_in;
    int          beats_seen;
    int          frames_opened;
    int          groups_dropped;
    bit          collecting;
    logic [1:0]  held_count;
    logic [7:0]  held [2];
    logic [8:0]  remaining;
    logic [8:0]  total;
    logic [8:0]  position;

    function new();
      errors = 0;
      bytes_in = 0;
      beats_seen = 0;
      frames_opened = 0;
      groups_dropped = 0;
      collecting = 1'b0;
      held_count = 2'd0;
      held[0] = 8'h00;
      held[1] = 8'h00;
      remaining = 9'd0;
      total = 9'd0;
      position = 9'd0;
    endfunction

    function void push_beat(logic [7:0] d, logic [8:0] p, logic [8:0] t, logic f, logic l);
      frame_beat_t beat;
      beat.data = d;
      beat.pos = p;
      beat.total = t;
      beat.first = f;
      beat.last = l;
      beats_due.insert(beats_due.size(), beat);
    endfunction

    // advance the delimiter state by one accepted input byte
    function void note_input(logic [7:0] b);
      bit is_last;
      int size;
      bytes_in++;
      if (collecting) begin
        is_last = (remaining <= 9'd1);
        push_beat(b, position, total, 1'b0, is_last);
        if (is_last) begin
          collecting = 1'b0;
          held_count = 2'd0;
          remaining = 9'd0;
          position = 9'd0;
        end else begin
          remaining = remaining - 9'd1;
          position = position + 9'd1;
        end
      end else if (held_count < 2'd2) begin
        held[held_count[0]] = b;
        held_count = held_count + 2'd1;
      end else begin
        held_count = 2'd0;
        if (held[0] != START_ONE || held[1] != START_TWO || b < MIN_LENGTH) begin
          groups_dropped++;
        end else begin
          size = frame_size(b);
          if (size > MAX_FRAME_BYTES) begin
            groups_dropped++;
          end else begin
            total = size[8:0];
            push_beat(held[0], 9'd0, total, 1'b1, 1'b0);
            push_beat(held[1], 9'd1, total, 1'b0, 1'b0);
            push_beat(b, 9'd2, total, 1'b0, 1'b0);
            collecting = 1'b1;
            position = HDR_BYTES;
            remaining = total - HDR_BYTES;
            frames_opened++;
          end
        end
      end
    endfunction

    // compare one output transfer with the oldest expected beat
    function void check_result(frame_beat_t got);
      frame_beat_t want;
      beats_seen++;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer byte=%h pos=%0d total=%0d first=%b last=%b",
                 $time, got.data, got.pos, got.total, got.first, got.last);
      end else begin
        want = beats_due[0];
        beats_due.delete(0);
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected byte=%h pos=%0d total=%0d first=%b last=%b",
                   $time, want.data, want.pos, want.total, want.first, want.last);
          $display("%0t:          actual   byte=%h pos=%0d total=%0d first=%b last=%b",
                   $time, got.data, got.pos, got.total, got.first, got.last);
        end
      end
    endfunction
  endclass

  frame_scoreboard sb;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  hold_req = 1'b0;

  link_frame_delimiter #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_frame_total   (out_frame_total),
    .out_first_of_frame(out_first_of_frame),
    .out_last_of_frame (out_last_of_frame)
  );

  always #6 clk = ~clk;

  // monitor: outputs first, since no result comes from an input of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result({out_frame_byte, out_byte_position, out_frame_total,
                         out_first_of_frame, out_last_of_frame});
      if (in_valid && in_ready)
        sb.note_input(in_rx_byte);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: duty-cycle stall pattern per segment, plus one long hold-off
  initial begin : receiver
    int  period;
    int  duty;
    int  phase;
    int  seg_left;
    int  hold_left;
    bit  hold_done;
    period = 1;
    duty = 1;
    phase = 0;
    seg_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 96);
          period = $urandom_range(1, 8);
          duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(1, period);
          phase = 0;
        end
        out_ready <= (phase < duty);
        phase = (phase + 1) % period;
        seg_left--;
      end
    end
  end

  // one input transfer; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    in_rx_byte <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender burst control around each byte
  task automatic offer(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    send_byte(b);
  endtask

  // random byte biased toward the sync values
  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return START_ONE;
    if (pick == 1) return START_TWO;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input logic [7:0] len);
    int body;
    offer(START_ONE);
    offer(START_TWO);
    offer(len);
    body = frame_size(len) - int'(HDR_BYTES);
    repeat (body) offer(rand_byte());
  endtask

  initial begin : stimulus
    logic [7:0] directed [$];
    int         sent;
    int         frames_sent;
    int         pick;
    int         skew;
    unit_kind_t kind;
    logic [7:0] len;

    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: dropped groups, short length, bad sync, then a minimum frame
    directed = '{8'hff, 8'hff, 8'hff,
                 START_ONE, START_TWO, 8'h04,
                 8'h00, START_TWO, MIN_LENGTH,
                 START_ONE, 8'h00, MIN_LENGTH,
                 START_ONE, START_TWO, MIN_LENGTH,
                 8'h00, 8'hff, START_ONE, START_TWO, 8'h55, 8'haa, 8'h01};
    foreach (directed[i]) offer(directed[i]);

    // random: mostly well-formed frames, some noise and broken headers
    sent = 0;
    frames_sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) kind = UNIT_FRAME;
      else if (pick < 80) kind = UNIT_NOISE;
      else if (pick < 88) kind = UNIT_SHORT_LEN;
      else if (pick < 95) kind = UNIT_BAD_SYNC;
      else kind = UNIT_SKEWED;
      if (sent > 100) hold_req = 1'b1;
      case (kind)
        UNIT_FRAME: begin
          pick = $urandom_range(0, 99);
          if (frames_sent == 2) len = 8'd255;
          else if (pick < 85) len = 8'($urandom_range(5, 40));
          else if (pick < 95) len = 8'($urandom_range(41, 120));
          else len = 8'($urandom_range(200, 255));
          send_frame(len);
          sent += frame_size(len);
          frames_sent++;
        end
        UNIT_NOISE: begin
          repeat (3) offer(rand_byte());
          sent += 3;
        end
        UNIT_SHORT_LEN: begin
          offer(START_ONE);
          offer(START_TWO);
          offer(8'($urandom_range(0, 4)));
          sent += 3;
        end
        UNIT_BAD_SYNC: begin
          if ($urandom_range(0, 1) == 0) begin
            offer(8'($urandom_range(0, 255)));
            offer(START_TWO);
          end else begin
            offer(START_ONE);
            offer(8'($urandom_range(0, 255)));
          end
          offer(8'($urandom_range(5, 255)));
          sent += 3;
        end
        UNIT_SKEWED: begin
          // header straddling group boundaries, then refill to realign
          skew = $urandom_range(1, 2);
          repeat (skew) offer(rand_byte());
          offer(START_ONE);
          offer(START_TWO);
          offer(8'($urandom_range(5, 40)));
          repeat (3 - skew) offer(rand_byte());
          sent += 6;
        end
        default: ;
      endcase
    end
    in_valid <= 1'b0;

    // drain: wait for every expected transfer, then a few more cycles
    while (sb.beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input bytes: %0d frames opened, %0d groups dropped",
             sb.bytes_in, sb.frames_opened, sb.groups_dropped);
    $display("checked %0d output transfers, %0d mismatches", sb.beats_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
